/* hw/rtl/flptw_pkg.sv */
// ----------------------------------------------------------------------------
// flptw_pkg
// Types and constants shared by the four-level page table walker modules.
// ----------------------------------------------------------------------------
package flptw_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int VA_WIDTH    = 48;
   localparam int PA_WIDTH    = 52;
   localparam int FRAME_WIDTH = 40;   // physical bits 51:12
   localparam int LOW_WIDTH   = 30;   // largest in-page offset (1 GiB)

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_ENTRY   = 1'b1
   } in_kind_type;

   typedef enum logic {
      RESULT_READ   = 1'b0,
      RESULT_FINISH = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NOT_PRESENT  = 2'd1,
      STATUS_HUGE_REFUSED = 2'd2,
      STATUS_UNEXPECTED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PAGE_4K = 2'd0,
      PAGE_2M = 2'd1,
      PAGE_1G = 2'd2
   } page_size_type;

   typedef enum logic [1:0] {
      LEVEL_PML4 = 2'd0,
      LEVEL_PDPT = 2'd1,
      LEVEL_PD   = 2'd2,
      LEVEL_PT   = 2'd3
   } level_type;

   typedef struct packed {
      logic                kind;
      logic [63:0]         root_table;
      logic [VA_WIDTH-1:0] virt_addr;
      logic [63:0]         entry_data;
      logic                read_failed;
   } req_item_type;

   typedef struct packed {
      logic                result_kind;
      logic [PA_WIDTH-1:0] read_addr;
      logic [1:0]          status;
      logic [PA_WIDTH-1:0] phys_addr;
      logic [1:0]          page_size;
   } rsp_item_type;

   // Classified work handed from the front to the back.
   typedef struct packed {
      result_kind_type         result_kind;
      status_type              status;
      page_size_type           page_size;
      logic [FRAME_WIDTH-1:0]  frame;
      logic [LOW_WIDTH-1:0]    low;
   } cmd_type;

endpackage

/* hw/rtl/four_level_page_table_walker_unit.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// A result reaches the rsp ports through the command queue and the registered result stage.
// Throughput: one item per cycle while the queue is not full, set by the front stage.
// Input and result sides stall on their own through a command queue.
// Reset: walk idle at the top level, 1 GiB pages refused, queue and
// result stage empty.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit #(
   parameter int QueueDepth = flptw_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic                    push,
   output logic                    full,
   input  flptw_pkg::req_item_type req_item,
   output logic                    empty,
   input  logic                    pop,
   output flptw_pkg::rsp_item_type rsp_item
);
   import flptw_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    accept;
   logic    queue_not_empty;
   logic    back_take;

   // An item transfers when pushed and the queue has room; the front
   // updates its walk state on the same edge.
   assign accept = push && !full;

   // Front: hold the walk level and virtual address, check each entry
   // and classify the item into a read or a finished translation.
   flptw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_item         (req_item),
      .cmd              (front_cmd)
   );

   // Queue: decouple the front from the result side so stalls on pop
   // do not stop new items until the queue fills.
   flptw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_data   (front_cmd),
      .full      (full),
      .rd_en     (back_take),
      .rd_data   (queue_cmd),
      .not_empty (queue_not_empty)
   );

   // Back: assemble read or physical address and register the result;
   // advance whenever the result stage is free or being popped.
   flptw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_cmd),
      .cmd_take  (back_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

/* hw/rtl/flptw_front.sv */
// ----------------------------------------------------------------------------
// flptw_front
// Walk state, entry checks and classification of each accepted item.
// ----------------------------------------------------------------------------
module flptw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic                   accept,
   input  flptw_pkg::req_item_type req_item,
   output flptw_pkg::cmd_type      cmd
);
   import flptw_pkg::*;

   level_type            level_ff, level_in;
   logic                 busy_ff, busy_in;
   logic [VA_WIDTH-1:0]  vaddr_ff, vaddr_in;
   logic                 huge_ff;
   level_type            level_next;
   logic                 present;
   logic                 large_page;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_PML4;
         busy_ff  <= 1'b0;
         huge_ff  <= 1'b0;
      end else begin
         if (accept) begin
            level_ff <= level_in;
            busy_ff  <= busy_in;
         end
         if (csr_write_enable) begin
            huge_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vaddr_ff <= vaddr_in;
      end
   end

   assign present    = req_item.entry_data[0] && !req_item.read_failed;
   assign large_page = req_item.entry_data[7];
   assign level_next = level_type'(level_ff + 2'd1);

   always_comb begin
      level_in        = level_ff;
      busy_in         = busy_ff;
      vaddr_in        = vaddr_ff;
      cmd.result_kind = RESULT_FINISH;
      cmd.status      = STATUS_OK;
      cmd.page_size   = PAGE_4K;
      cmd.frame       = '0;
      cmd.low         = '0;

      if (req_item.kind == KIND_REQUEST) begin
         vaddr_in        = req_item.virt_addr;
         level_in        = LEVEL_PML4;
         busy_in         = 1'b1;
         cmd.result_kind = RESULT_READ;
         cmd.frame       = req_item.root_table[PA_WIDTH-1:12];
         cmd.low         = {18'd0, req_item.virt_addr[47:39], 3'd0};
      end else if (!busy_ff) begin
         cmd.status = STATUS_UNEXPECTED;
      end else if (!present) begin
         busy_in    = 1'b0;
         level_in   = LEVEL_PML4;
         cmd.status = STATUS_NOT_PRESENT;
      end else if (level_ff == LEVEL_PDPT && large_page) begin
         busy_in  = 1'b0;
         level_in = LEVEL_PML4;
         if (!huge_ff) begin
            cmd.status = STATUS_HUGE_REFUSED;
         end else begin
            cmd.page_size = PAGE_1G;
            cmd.frame     = req_item.entry_data[PA_WIDTH-1:12];
            cmd.low       = vaddr_ff[LOW_WIDTH-1:0];
         end
      end else if (level_ff == LEVEL_PD && large_page) begin
         busy_in       = 1'b0;
         level_in      = LEVEL_PML4;
         cmd.page_size = PAGE_2M;
         cmd.frame     = req_item.entry_data[PA_WIDTH-1:12];
         cmd.low       = vaddr_ff[LOW_WIDTH-1:0];
      end else if (level_ff == LEVEL_PT) begin
         busy_in   = 1'b0;
         level_in  = LEVEL_PML4;
         cmd.frame = req_item.entry_data[PA_WIDTH-1:12];
         cmd.low   = vaddr_ff[LOW_WIDTH-1:0];
      end else begin
         // descend one level and fetch the next entry
         level_in        = level_next;
         cmd.result_kind = RESULT_READ;
         cmd.frame       = req_item.entry_data[PA_WIDTH-1:12];
         case (level_next)
            LEVEL_PDPT: cmd.low = {18'd0, vaddr_ff[38:30], 3'd0};
            LEVEL_PD:   cmd.low = {18'd0, vaddr_ff[29:21], 3'd0};
            LEVEL_PT:   cmd.low = {18'd0, vaddr_ff[20:12], 3'd0};
            default:    cmd.low = {18'd0, vaddr_ff[47:39], 3'd0};
         endcase
      end
   end

endmodule

/* hw/rtl/flptw_queue.sv */
// ----------------------------------------------------------------------------
// flptw_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module flptw_queue #(
   parameter int Depth = flptw_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  flptw_pkg::cmd_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output flptw_pkg::cmd_type rd_data,
   output logic               not_empty
);
   import flptw_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   cmd_type                slot_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   do_wr, do_rd;

   assign full      = (count_ff == CountWidth'(Depth));
   assign not_empty = (count_ff != '0);
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;
   assign rd_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hw/rtl/flptw_back.sv */
// ----------------------------------------------------------------------------
// flptw_back
// Address assembly from a command and the registered result stage.
// ----------------------------------------------------------------------------
module flptw_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  flptw_pkg::cmd_type      cmd,
   output logic                    cmd_take,
   output logic                    empty,
   input  logic                    pop,
   output flptw_pkg::rsp_item_type rsp_item
);
   import flptw_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic [PA_WIDTH-1:0]  merged;

   // splice frame and offset at the page boundary
   always_comb begin
      case (cmd.page_size)
         PAGE_1G: merged = {cmd.frame[FRAME_WIDTH-1:18], cmd.low[29:0]};
         PAGE_2M: merged = {cmd.frame[FRAME_WIDTH-1:9], cmd.low[20:0]};
         default: merged = {cmd.frame, cmd.low[11:0]};
      endcase
   end

   assign cmd_take = cmd_valid && (!rsp_valid_ff || pop);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (cmd_take) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.result_kind = cmd.result_kind;
         rsp_item_in.status      = cmd.status;
         rsp_item_in.page_size   = cmd.page_size;
         rsp_item_in.read_addr   = (cmd.result_kind == RESULT_READ) ? merged : '0;
         rsp_item_in.phys_addr   = (cmd.result_kind == RESULT_FINISH &&
                                    cmd.status == STATUS_OK) ? merged : '0;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

/* dv/tb_four_level_page_table_walker_unit.sv */
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_unit
// Self-checking bench for the page table walker. A directed table walks the
// boundary cases, then random walks (mostly well formed, some abandoned or
// stray) run in phases of either huge page setting. Each result transfer is
// compared with its row's typed answer or a walk predictor fed accepted items.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_unit;
   import flptw_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_ITEMS    = 1150;
   localparam int SETTING_PHASES  = 5;
   localparam int PTE_PRESENT_BIT = 0;
   localparam int PTE_LARGE_BIT   = 7;
   localparam int DIRECTED_ROWS   = 26;

   // Receiver stall patterns.
   localparam int POP_STEADY  = 0;
   localparam int POP_COIN    = 1;
   localparam int POP_SPARSE  = 2;
   localparam int POP_BLOCKED = 3;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_action_type;

   typedef struct packed {
      row_action_type action;
      logic           csr_value;
      req_item_type   item;
      logic           fixed;
      rsp_item_type   want;
   } stim_row_type;

   localparam rsp_item_type NO_CHECK        = '0;
   localparam rsp_item_type RSP_READ_ZERO   = '0;
   localparam rsp_item_type RSP_READ_TOP    =
      '{RESULT_READ, 52'hF_FFFF_FFFF_FFF8, STATUS_OK, 52'h0, PAGE_4K};
   localparam rsp_item_type RSP_UNEXPECTED  =
      '{RESULT_FINISH, 52'h0, STATUS_UNEXPECTED, 52'h0, PAGE_4K};
   localparam rsp_item_type RSP_NOT_PRESENT =
      '{RESULT_FINISH, 52'h0, STATUS_NOT_PRESENT, 52'h0, PAGE_4K};
   localparam rsp_item_type RSP_REFUSED     =
      '{RESULT_FINISH, 52'h0, STATUS_HUGE_REFUSED, 52'h0, PAGE_4K};

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data   = 1'b0;
   logic         push             = 1'b0;
   logic         full;
   req_item_type req_item         = '0;
   logic         empty;
   logic         pop              = 1'b0;
   rsp_item_type rsp_item;

   // Typed expectation travelling alongside the item on the input side.
   logic         fixed_check      = 1'b0;
   rsp_item_type fixed_want       = '0;

   // Walker model state and register copy.
   level_type    walk_level       = LEVEL_PML4;
   logic         walk_busy        = 1'b0;
   logic [47:0]  walk_vaddr       = '0;
   logic         huge_allowed     = 1'b0;

   rsp_item_type awaited_results[$];
   int           mismatch_count   = 0;
   int           cycle_count      = 0;
   int           items_sent       = 0;
   int           burst_left       = 0;
   int           pop_mode         = POP_STEADY;
   int           pop_mode_left    = 0;
   stim_row_type directed_rows [DIRECTED_ROWS];

   four_level_page_table_walker_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .full             (full),
      .req_item         (req_item),
      .empty            (empty),
      .pop              (pop),
      .rsp_item         (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Address of the table entry selected by the VA index for this level.
   function automatic logic [51:0] table_entry_addr(logic [63:0] base, logic [47:0] va,
                                                    level_type lvl);
      logic [8:0] index;
      case (lvl)
         LEVEL_PML4: index = va[47:39];
         LEVEL_PDPT: index = va[38:30];
         LEVEL_PD:   index = va[29:21];
         default:    index = va[20:12];
      endcase
      return {base[51:12], index, 3'b000};
   endfunction

   // Advance the walk by one accepted item and return the result it causes.
   function automatic rsp_item_type next_walk_result(req_item_type it);
      rsp_item_type r;
      logic [47:0]  va;
      logic         large_page;
      r          = '0;
      va         = walk_vaddr;
      large_page = it.entry_data[PTE_LARGE_BIT];
      if (it.kind == KIND_REQUEST) begin
         // A request always restarts, abandoning any walk in progress.
         walk_vaddr  = it.virt_addr;
         walk_level  = LEVEL_PML4;
         walk_busy   = 1'b1;
         r.read_addr = table_entry_addr(it.root_table, it.virt_addr, LEVEL_PML4);
      end else if (!walk_busy) begin
         r.result_kind = RESULT_FINISH;
         r.status      = STATUS_UNEXPECTED;
      end else if (it.read_failed || !it.entry_data[PTE_PRESENT_BIT]) begin
         walk_busy     = 1'b0;
         walk_level    = LEVEL_PML4;
         r.result_kind = RESULT_FINISH;
         r.status      = STATUS_NOT_PRESENT;
      end else if (walk_level == LEVEL_PDPT && large_page) begin
         walk_busy     = 1'b0;
         walk_level    = LEVEL_PML4;
         r.result_kind = RESULT_FINISH;
         if (huge_allowed) begin
            r.phys_addr = {it.entry_data[51:30], va[29:0]};
            r.page_size = PAGE_1G;
         end else begin
            r.status = STATUS_HUGE_REFUSED;
         end
      end else if (walk_level == LEVEL_PD && large_page) begin
         walk_busy     = 1'b0;
         walk_level    = LEVEL_PML4;
         r.result_kind = RESULT_FINISH;
         r.phys_addr   = {it.entry_data[51:21], va[20:0]};
         r.page_size   = PAGE_2M;
      end else if (walk_level == LEVEL_PT) begin
         // The large bit means nothing at the last level.
         walk_busy     = 1'b0;
         walk_level    = LEVEL_PML4;
         r.result_kind = RESULT_FINISH;
         r.phys_addr   = {it.entry_data[51:12], va[11:0]};
         r.page_size   = PAGE_4K;
      end else begin
         walk_level  = level_type'(walk_level + 2'd1);
         r.read_addr = table_entry_addr(it.entry_data, va, walk_level);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR @%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Monitor: sample both handshakes at the edge, check results, then predict.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type predicted;
      if (reset) begin
         walk_level   = LEVEL_PML4;
         walk_busy    = 1'b0;
         walk_vaddr   = '0;
         huge_allowed = 1'b0;
      end else begin
         if (csr_write_enable) begin
            huge_allowed = csr_write_data;
         end
         if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result transfer with nothing awaited",
                               64'(rsp_item.status), '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_item.result_kind !== want.result_kind)
                  report_mismatch("result_kind", 64'(rsp_item.result_kind),
                                  64'(want.result_kind));
               if (rsp_item.read_addr !== want.read_addr)
                  report_mismatch("read_addr", 64'(rsp_item.read_addr),
                                  64'(want.read_addr));
               if (rsp_item.status !== want.status)
                  report_mismatch("status", 64'(rsp_item.status), 64'(want.status));
               if (rsp_item.phys_addr !== want.phys_addr)
                  report_mismatch("phys_addr", 64'(rsp_item.phys_addr),
                                  64'(want.phys_addr));
               if (rsp_item.page_size !== want.page_size)
                  report_mismatch("page_size", 64'(rsp_item.page_size),
                                  64'(want.page_size));
            end
         end
         if (push && !full) begin
            // Keep the model in step even where the row carries a typed answer.
            predicted = next_walk_result(req_item);
            awaited_results.push_back(fixed_check ? fixed_want : predicted);
         end
      end
   end

   // Receiver: hold each stall pattern for a random stretch, then pick another.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop_mode_left == 0) begin
            pop_mode      = $urandom_range(POP_STEADY, POP_BLOCKED);
            pop_mode_left = $urandom_range(16, 160);
         end
         pop_mode_left--;
         case (pop_mode)
            POP_STEADY: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= (pop_mode_left % 12 == 0);
         endcase
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("four_level_page_table_walker_unit verification failed");
         $finish;
      end
   end

   function automatic req_item_type walk_request(logic [63:0] root, logic [47:0] va);
      req_item_type it;
      it            = '0;
      it.kind       = KIND_REQUEST;
      it.root_table = root;
      it.virt_addr  = va;
      return it;
   endfunction

   function automatic req_item_type table_entry(logic [63:0] data, logic failed);
      req_item_type it;
      it             = '0;
      it.kind        = KIND_ENTRY;
      it.entry_data  = data;
      it.read_failed = failed;
      return it;
   endfunction

   function automatic logic [63:0] rand_qword();
      return {$urandom, $urandom};
   endfunction

   // Fill every field with noise; only the kind is chosen.
   function automatic req_item_type random_item(in_kind_type kind);
      req_item_type it;
      it.kind        = kind;
      it.root_table  = rand_qword();
      it.virt_addr   = 48'(rand_qword());
      it.entry_data  = rand_qword();
      it.read_failed = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Offer one item and hold it until its transfer; idle between bursts.
   task automatic transfer_item(req_item_type it, logic fixed, rsp_item_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      push        <= 1'b1;
      req_item    <= it;
      fixed_check <= fixed;
      fixed_want  <= want;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   // Drop push and wait until every awaited result has been taken.
   task automatic wait_walker_idle();
      push <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_huge_pages(logic value);
      wait_walker_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One walk: mostly well formed, sometimes a stray entry or a walk left
   // hanging so that the next request abandons it.
   task automatic run_random_walk();
      int           style;
      req_item_type it;
      logic         large_page;
      logic         huge_level;
      style = $urandom_range(0, 99);
      if (style < 6) begin
         transfer_item(random_item(KIND_ENTRY), 1'b0, NO_CHECK);
         return;
      end
      transfer_item(random_item(KIND_REQUEST), 1'b0, NO_CHECK);
      for (int lvl = 0; lvl < 4; lvl++) begin
         if (style < 14 && $urandom_range(0, 3) == 0) return;
         huge_level = (lvl == 1 || lvl == 2);
         it = random_item(KIND_ENTRY);
         it.read_failed = ($urandom_range(0, 24) == 0);
         it.entry_data[PTE_PRESENT_BIT] = ($urandom_range(0, 19) != 0);
         large_page = huge_level ? ($urandom_range(0, 3) == 0)
                                 : 1'($urandom_range(0, 1));
         it.entry_data[PTE_LARGE_BIT] = large_page;
         transfer_item(it, 1'b0, NO_CHECK);
         if (it.read_failed || !it.entry_data[PTE_PRESENT_BIT] ||
             (large_page && huge_level))
            return;
      end
   endtask

   initial begin
      int target;
      directed_rows = '{
         // entry with no walk running
         '{ROW_ITEM, 1'b0, table_entry(64'h0, 1'b0), 1'b1, RSP_UNEXPECTED},
         // all-ones root and VA select the very last top-level slot
         '{ROW_ITEM, 1'b0, walk_request('1, '1), 1'b1, RSP_READ_TOP},
         // failed read wins over a present entry
         '{ROW_ITEM, 1'b0, table_entry('1, 1'b1), 1'b1, RSP_NOT_PRESENT},
         '{ROW_ITEM, 1'b0, walk_request(64'h0, 48'h0), 1'b1, RSP_READ_ZERO},
         '{ROW_ITEM, 1'b0, table_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b0), 1'b1,
           RSP_NOT_PRESENT},
         // large bit at the top level is ignored, then 1 GiB refused
         '{ROW_ITEM, 1'b0, walk_request(64'h0123_4567_89AB_CDEF, 48'h8000_4020_1ABC),
           1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0000_0000_1234_5081, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h000F_FFFF_C000_0081, 1'b0), 1'b1, RSP_REFUSED},
         // 2 MiB page
         '{ROW_ITEM, 1'b0, walk_request(64'hFFF0_0000_0000_0FFF, 48'h7FFF_FFFF_FFFF),
           1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h8000_0000_0000_0003, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0005_5555_5555_5001, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h000A_AAAA_AAA0_0081, 1'b0), 1'b0, NO_CHECK},
         // full 4 KiB walk, large bit set on the last entry
         '{ROW_ITEM, 1'b0, walk_request(64'h0000_1234_5678_9000, 48'h0000_4020_100F),
           1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0000_0000_0001_0001, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0000_0000_0002_0023, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0000_0000_0003_0003, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry('1, 1'b0), 1'b0, NO_CHECK},
         // request in the middle of a walk abandons it
         '{ROW_ITEM, 1'b0, walk_request(64'h0000_0000_ABCD_E000, 48'hA5A5_5A5A_A5A5),
           1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0000_0000_0004_0001, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, walk_request(64'h0000_0000_0000_7000, 48'h5A5A_A5A5_5A5A),
           1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry('1, 1'b1), 1'b1, RSP_NOT_PRESENT},
         // 1 GiB page once allowed
         '{ROW_CSR,  1'b1, '0, 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, walk_request('1, '1), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry(64'h0000_0000_0000_0001, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry('1, 1'b0), 1'b0, NO_CHECK},
         '{ROW_ITEM, 1'b0, table_entry('1, 1'b1), 1'b1, RSP_UNEXPECTED}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].action == ROW_CSR) begin
            set_huge_pages(directed_rows[i].csr_value);
         end else begin
            transfer_item(directed_rows[i].item, directed_rows[i].fixed,
                          directed_rows[i].want);
         end
      end

      // Random walks, cycling the huge page setting between phases.
      for (int phase = 0; phase < SETTING_PHASES; phase++) begin
         set_huge_pages((phase == 1 || phase == 2 || phase == 4) ? 1'b1 : 1'b0);
         target = items_sent + RANDOM_ITEMS / SETTING_PHASES;
         while (items_sent < target) run_random_walk();
      end

      wait_walker_idle();
      // Let any stray result surface.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("four_level_page_table_walker_unit verification clean");
      end else begin
         $display("four_level_page_table_walker_unit verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/flptw_pkg.sv
hw/rtl/flptw_front.sv
hw/rtl/flptw_queue.sv
hw/rtl/flptw_back.sv
hw/rtl/four_level_page_table_walker_unit.sv
dv/tb_four_level_page_table_walker_unit.sv
